// File: rtl/blepdu_pkg.sv
// Shared types and constants for the accessory PDU parser.
// Holds the control field masks, the item and result structs, phase codes and status codes.
// No dependencies; every other file imports this package.
package blepdu_pkg;

  // Control field bit masks.
  localparam logic [7:0] CTRL_RSVD_MASK = 8'h70;   // reserved bits, must be zero
  localparam logic [7:0] CTRL_TYPE_MASK = 8'h0E;   // type field
  localparam logic [7:0] CTRL_TYPE_RSP  = 8'h02;   // type code of a response
  localparam logic [7:0] CTRL_LEN_BIT   = 8'h01;   // length bit, must be zero

  // Parse phases.
  localparam logic [3:0] PH_CTRL     = 4'd0;
  localparam logic [3:0] PH_REQ_OPC  = 4'd1;
  localparam logic [3:0] PH_REQ_TID  = 4'd2;
  localparam logic [3:0] PH_IID_LO   = 4'd3;
  localparam logic [3:0] PH_IID_HI   = 4'd4;
  localparam logic [3:0] PH_RSP_TID  = 4'd5;
  localparam logic [3:0] PH_RSP_STAT = 4'd6;
  localparam logic [3:0] PH_LEN_LO   = 4'd7;
  localparam logic [3:0] PH_LEN_HI   = 4'd8;
  localparam logic [3:0] PH_BODY     = 4'd9;
  localparam logic [3:0] PH_CONT_TID = 4'd10;
  localparam logic [3:0] PH_SINK     = 4'd11;

  // Parse status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CTRL = 3'd1;
  localparam logic [2:0] ST_BAD_FRAG = 3'd2;
  localparam logic [2:0] ST_TYPE_MIS = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_EXCESS   = 3'd5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        continuation_mode;
    logic        first_type;
    logic [15:0] remaining_body_bytes;
    logic [15:0] body_bytes_so_far;
  } item_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        done_res;
    logic [2:0]  parse_status;
    logic        pdu_type;
    logic        is_continuation;
    logic [7:0]  opcode;
    logic [7:0]  transaction_id;
    logic [15:0] instance_id;
    logic [7:0]  response_status;
    logic [15:0] total_body_length;
    logic [15:0] fragment_body_length;
  } result_t;

endpackage

// File: rtl/blepdu_in_reg.sv
// Input register stage of the PDU parser; uses blepdu_pkg.
// Captures one item per cycle unless stalled and hands it to the parse stage.
module blepdu_in_reg
  import blepdu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,     // downstream takes the held item this cycle
  output logic  held_valid,
  output item_t held_item
);

  logic  valid;
  item_t item;

  assign in_ready   = !valid || advance;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/blepdu_parse.sv
// Parse stage: per-PDU state registers and the byte-wise phase logic.
// Produces one result per item in the same cycle; uses blepdu_pkg.
module blepdu_parse
  import blepdu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,      // the held item is consumed this cycle
  input  item_t   item,
  output result_t res
);

  logic [3:0]  phase, phase_step, phase_next;
  logic [2:0]  error_code, error_code_next;
  logic        latched_mode, latched_mode_next;
  logic        latched_type, latched_type_next;
  logic [7:0]  captured_opcode, captured_opcode_next;
  logic [7:0]  captured_tid, captured_tid_next;
  logic [15:0] captured_iid, captured_iid_next;
  logic [7:0]  captured_status, captured_status_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] body_count, body_count_next;
  logic [15:0] body_allowance, body_allowance_next;
  logic        bvalid;
  logic        ctrl_bad;
  logic [7:0]  b;

  assign b = item.data_byte;
  assign ctrl_bad = ((b & CTRL_RSVD_MASK) != 8'd0) || ((b & CTRL_LEN_BIT) != 8'd0) ||
                    (((b & CTRL_TYPE_MASK) != 8'd0) &&
                     ((b & CTRL_TYPE_MASK) != CTRL_TYPE_RSP));

  always_comb begin
    phase_step            = phase;
    error_code_next       = error_code;
    latched_mode_next     = latched_mode;
    latched_type_next     = latched_type;
    captured_opcode_next  = captured_opcode;
    captured_tid_next     = captured_tid;
    captured_iid_next     = captured_iid;
    captured_status_next  = captured_status;
    announced_length_next = announced_length;
    body_count_next       = body_count;
    body_allowance_next   = body_allowance;
    bvalid                = 1'b0;

    case (phase)
      PH_CTRL: begin
        // A control byte starts a new PDU and clears everything captured.
        error_code_next       = ST_OK;
        latched_mode_next     = item.continuation_mode;
        latched_type_next     = 1'b0;
        captured_opcode_next  = 8'd0;
        captured_tid_next     = 8'd0;
        captured_iid_next     = 16'd0;
        captured_status_next  = 8'd0;
        announced_length_next = 16'd0;
        body_count_next       = 16'd0;
        body_allowance_next   = 16'd0;
        if (ctrl_bad) begin
          error_code_next = ST_BAD_CTRL;
          phase_step      = PH_SINK;
        end else begin
          latched_type_next = b[1];
          if (b[7] != item.continuation_mode) begin
            error_code_next = ST_BAD_FRAG;
            phase_step      = PH_SINK;
          end else if (item.continuation_mode) begin
            if (b[1] != item.first_type) begin
              error_code_next = ST_TYPE_MIS;
              phase_step      = PH_SINK;
            end else begin
              announced_length_next = item.remaining_body_bytes;
              body_allowance_next   =
                (item.remaining_body_bytes >= item.body_bytes_so_far) ?
                (item.remaining_body_bytes - item.body_bytes_so_far) : 16'd0;
              phase_step            = PH_CONT_TID;
            end
          end else begin
            phase_step = b[1] ? PH_RSP_TID : PH_REQ_OPC;
          end
        end
      end
      PH_REQ_OPC: begin
        captured_opcode_next = b;
        phase_step           = PH_REQ_TID;
      end
      PH_REQ_TID: begin
        captured_tid_next = b;
        phase_step        = PH_IID_LO;
      end
      PH_IID_LO: begin
        captured_iid_next = {8'd0, b};
        phase_step        = PH_IID_HI;
      end
      PH_IID_HI: begin
        captured_iid_next = {b, captured_iid[7:0]};
        phase_step        = PH_LEN_LO;
      end
      PH_RSP_TID: begin
        captured_tid_next = b;
        phase_step        = PH_RSP_STAT;
      end
      PH_RSP_STAT: begin
        captured_status_next = b;
        phase_step           = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        announced_length_next = {8'd0, b};
        phase_step            = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        announced_length_next = {b, announced_length[7:0]};
        body_allowance_next   = {b, announced_length[7:0]};
        phase_step            = PH_BODY;
      end
      PH_CONT_TID: begin
        captured_tid_next = b;
        phase_step        = PH_BODY;
      end
      PH_BODY: begin
        if (body_count < body_allowance) begin
          bvalid          = 1'b1;
          body_count_next = 16'(body_count + 16'd1);
        end else begin
          error_code_next = ST_EXCESS;
          phase_step      = PH_SINK;
        end
      end
      default: begin
        phase_step = PH_SINK;
      end
    endcase

    // Ending anywhere but after the fixed parameters or inside the body is short.
    if (item.last_byte && (error_code_next == ST_OK) &&
        (phase_step != PH_LEN_LO) && (phase_step != PH_BODY)) begin
      error_code_next = ST_TRUNC;
    end

    phase_next = item.last_byte ? PH_CTRL : phase_step;
  end

  always_comb begin
    res.body_valid           = bvalid;
    res.body_byte            = bvalid ? b : 8'd0;
    res.done_res             = item.last_byte;
    res.parse_status         = error_code_next;
    res.opcode               = captured_opcode_next;
    res.transaction_id       = captured_tid_next;
    res.instance_id          = captured_iid_next;
    res.response_status      = captured_status_next;
    res.total_body_length    = announced_length_next;
    res.fragment_body_length = body_count_next;
    if (error_code_next == ST_BAD_CTRL) begin
      res.is_continuation = 1'b0;
      res.pdu_type        = 1'b0;
    end else if (error_code_next == ST_BAD_FRAG) begin
      res.is_continuation = !latched_mode_next;
      res.pdu_type        = latched_type_next;
    end else begin
      res.is_continuation = latched_mode_next;
      res.pdu_type        = latched_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CTRL;
      error_code       <= ST_OK;
      latched_mode     <= 1'b0;
      latched_type     <= 1'b0;
      captured_opcode  <= 8'd0;
      captured_tid     <= 8'd0;
      captured_iid     <= 16'd0;
      captured_status  <= 8'd0;
      announced_length <= 16'd0;
      body_count       <= 16'd0;
      body_allowance   <= 16'd0;
    end else if (fire) begin
      phase            <= phase_next;
      error_code       <= error_code_next;
      latched_mode     <= latched_mode_next;
      latched_type     <= latched_type_next;
      captured_opcode  <= captured_opcode_next;
      captured_tid     <= captured_tid_next;
      captured_iid     <= captured_iid_next;
      captured_status  <= captured_status_next;
      announced_length <= announced_length_next;
      body_count       <= body_count_next;
      body_allowance   <= body_allowance_next;
    end
  end

  // A body byte is only ever passed through while no error is pending.
  a_body_ok: assert property (@(posedge clk) disable iff (rst)
    (fire && res.body_valid) |-> (res.parse_status == ST_OK))
    else $error("body byte passed with an error status");

  // The item after a last byte is always parsed as a control byte.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && item.last_byte) |=> (phase == PH_CTRL))
    else $error("parser did not return to the control phase after a last byte");

  // The body count never runs past the allowance while in the body.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_count <= body_allowance))
    else $error("body count exceeds allowance");

endmodule

// File: rtl/blepdu_out_reg.sv
// Output register of the PDU parser.
// Holds one finished result until the downstream side takes it; uses blepdu_pkg.
module blepdu_out_reg
  import blepdu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,       // a new result is written this cycle
  input  result_t load_res,
  output logic    advance,    // the register can take a result this cycle
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid;
  result_t res;

  assign advance   = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

// File: rtl/ble_accessory_pdu_parser_top.sv
// Top level of the streaming accessory PDU parser.
// Instantiates blepdu_in_reg, blepdu_parse and blepdu_out_reg; uses blepdu_pkg.
// A byte is held in the input register, parsed combinationally, and its result is
// held in the output register until the master side takes it. Throughput: one byte
// per cycle unless m_tready stalls; the parse logic is a single shallow pass per byte.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to expecting a control byte with all captured values cleared.
module ble_accessory_pdu_parser_top
  import blepdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte[7:0], remaining_body_bytes[23:8],
                                 // body_bytes_so_far[39:24]
  input  logic [1:0]  s_tuser,   // continuation_mode[0], first_type[1]
  input  logic        s_tlast,   // last_byte
  // Result stream, one result per input item.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // body_byte[7:0], parse_status[10:8], pdu_type[11],
                                 // is_continuation[12], opcode[20:13],
                                 // transaction_id[28:21], instance_id[44:29],
                                 // response_status[52:45], total_body_length[68:53],
                                 // fragment_body_length[84:69], zero pad[87:85]
  output logic        m_tuser,   // body_valid
  output logic        m_tlast    // done_res
);

  item_t   s_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    fire;
  result_t parse_res;
  result_t out_res;

  // Unpack the slave side into an item.
  always_comb begin
    s_item.data_byte            = s_tdata[7:0];
    s_item.remaining_body_bytes = s_tdata[23:8];
    s_item.body_bytes_so_far    = s_tdata[39:24];
    s_item.continuation_mode    = s_tuser[0];
    s_item.first_type           = s_tuser[1];
    s_item.last_byte            = s_tlast;
  end

  // The input register accepts a new item whenever its held item moves on,
  // so a stall on the master side pulls s_tready low only once both registers
  // hold an item.
  blepdu_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (s_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // The parse state advances exactly when a held item is written to the output.
  assign fire = held_valid && advance;

  blepdu_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .res  (parse_res)
  );

  blepdu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_res  (parse_res),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the result onto the master side.
  assign m_tdata = {3'd0,
                    out_res.fragment_body_length,
                    out_res.total_body_length,
                    out_res.response_status,
                    out_res.instance_id,
                    out_res.transaction_id,
                    out_res.opcode,
                    out_res.is_continuation,
                    out_res.pdu_type,
                    out_res.parse_status,
                    out_res.body_byte};
  assign m_tuser = out_res.body_valid;
  assign m_tlast = out_res.done_res;

endmodule
